// File: hw/rtl/iscsi_pdu_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// iscsi_pdu_deframer_core_macros
// Assertion macros for the PDU deframer. Empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ISCSI_PDU_DEFRAMER_CORE_MACROS_SVH
`define ISCSI_PDU_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset
`define IPDU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, disabled during reset
`define IPDU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`else

`define IPDU_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define IPDU_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hw/rtl/ipdu_pkg.sv
// ----------------------------------------------------------------------------
// ipdu_pkg
// Types and constants shared by the PDU deframer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ipdu_pkg;

   // Section of the PDU a byte belongs to; also the tracker state
   typedef enum logic [1:0] {
      SEC_HEADER = 2'd0,
      SEC_AHS    = 2'd1,
      SEC_DATA   = 2'd2,
      SEC_PAD    = 2'd3
   } section_type;

   // Header byte positions of the length fields
   localparam logic [23:0] AHS_BYTE_POS  = 24'd4;
   localparam logic [23:0] DLEN_HI_POS   = 24'd5;
   localparam logic [23:0] DLEN_MID_POS  = 24'd6;
   localparam logic [23:0] DLEN_LO_POS   = 24'd7;

   typedef struct packed {
      logic [7:0]  out_byte;
      section_type section;
      logic [23:0] section_offset;
      logic        pdu_end;
      logic [9:0]  ahs_bytes;
      logic [23:0] data_bytes;
   } result_type;

endpackage

// File: hw/rtl/ipdu_req_if.sv
// ----------------------------------------------------------------------------
// ipdu_req_if
// Byte stream channel into the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipdu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

// File: hw/rtl/ipdu_rsp_if.sv
// ----------------------------------------------------------------------------
// ipdu_rsp_if
// Tagged byte channel out of the deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ipdu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  section;
   logic [23:0] section_offset;
   logic        pdu_end;
   logic [9:0]  ahs_bytes;
   logic [23:0] data_bytes;

   modport source (output valid, output out_byte, output section,
                   output section_offset, output pdu_end, output ahs_bytes,
                   output data_bytes, input ready);
   modport sink   (input valid, input out_byte, input section,
                   input section_offset, input pdu_end, input ahs_bytes,
                   input data_bytes, output ready);
endinterface

// File: hw/rtl/iscsi_pdu_deframer_core.sv
// ----------------------------------------------------------------------------
// iscsi_pdu_deframer_core
// Splits a connection byte stream into PDUs and tags every byte with its
// section, offset in section and end-of-PDU flag.
// ----------------------------------------------------------------------------
// Takes one byte per clock and returns one tagged item per byte, in order.
// Throughput is one item per cycle while the sink is ready; an input register
// is followed by a result register, with the section tracker between them. The
// input register takes a byte when it is empty or its byte moves on, so a byte
// is taken while a finished result waits for its sink only if the input register
// is empty. The stream must start at a PDU boundary after reset; there is no
// resynchronisation. Length fields read zero on header bytes before the last one.
`timescale 1ns / 1ps
`include "iscsi_pdu_deframer_core_macros.svh"

module iscsi_pdu_deframer_core
   import ipdu_pkg::*;
#(
   parameter int unsigned HEADER_BYTES = 48
) (
   input  logic        clock,
   input  logic        reset,
   ipdu_req_if.sink    req,
   ipdu_rsp_if.source  rsp
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;
   logic       advance;

   // the stored byte moves on when the result slot is free or being drained
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req.valid && req.ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_byte_ff <= req.stream_byte;
      if (advance) rsp_data_ff <= result;
   end

   ipdu_tracker #(
      .HEADER_BYTES (HEADER_BYTES)
   ) u_tracker (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .result  (result)
   );

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.out_byte       = rsp_data_ff.out_byte;
   assign rsp.section        = rsp_data_ff.section;
   assign rsp.section_offset = rsp_data_ff.section_offset;
   assign rsp.pdu_end        = rsp_data_ff.pdu_end;
   assign rsp.ahs_bytes      = rsp_data_ff.ahs_bytes;
   assign rsp.data_bytes     = rsp_data_ff.data_bytes;

   `IPDU_ASSERT_IMPLIES(a_hdr_offset, clock, reset, rsp.valid && rsp.section == SEC_HEADER, rsp.section_offset < 24'(HEADER_BYTES))
   `IPDU_ASSERT_IMPLIES(a_ahs_offset, clock, reset, rsp.valid && rsp.section == SEC_AHS, rsp.section_offset < {14'b0, rsp.ahs_bytes})
   `IPDU_ASSERT_IMPLIES(a_data_offset, clock, reset, rsp.valid && rsp.section == SEC_DATA, rsp.section_offset < rsp.data_bytes)
   `IPDU_ASSERT_IMPLIES(a_pad_offset, clock, reset, rsp.valid && rsp.section == SEC_PAD, rsp.section_offset < 24'd3)
   `IPDU_ASSERT_NEXT(a_stall_hold, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

// File: hw/rtl/ipdu_tracker.sv
// ----------------------------------------------------------------------------
// ipdu_tracker
// Section state machine: tags each byte, captures the length fields and
// flags the last byte of a PDU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ipdu_tracker
   import ipdu_pkg::*;
#(
   parameter int unsigned HEADER_BYTES = 48
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   output result_type result
);

   localparam logic [23:0] HDR_LAST = 24'(HEADER_BYTES - 1);

   section_type section_ff, section_in;
   logic [23:0] off_ff, off_in;
   logic [7:0]  ahs_ff, ahs_in;
   logic [23:0] dlen_ff, dlen_in;

   logic [24:0] off_plus1;
   logic [9:0]  ahsb_now;
   logic [9:0]  ahsb_ff;
   logic [1:0]  pad_len;

   always_ff @(posedge clock) begin
      if (reset) begin
         section_ff <= SEC_HEADER;
         off_ff     <= '0;
         ahs_ff     <= '0;
         dlen_ff    <= '0;
      end else if (step) begin
         section_ff <= section_in;
         off_ff     <= off_in;
         ahs_ff     <= ahs_in;
         dlen_ff    <= dlen_in;
      end
   end

   always_comb begin
      off_plus1 = {1'b0, off_ff} + 25'd1;
      ahsb_ff   = {ahs_ff, 2'b00};
      pad_len   = 2'b00 - dlen_ff[1:0];

      ahs_in     = ahs_ff;
      dlen_in    = dlen_ff;
      section_in = section_ff;
      off_in     = off_plus1[23:0];

      result.out_byte       = byte_in;
      result.section        = section_ff;
      result.section_offset = off_ff;
      result.pdu_end        = 1'b0;
      result.ahs_bytes      = ahsb_ff;
      result.data_bytes     = dlen_ff;

      // capture goes first so a minimal header sees its own last length byte
      if (section_ff == SEC_HEADER) begin
         if (off_ff == AHS_BYTE_POS) ahs_in = byte_in;
         if (off_ff == DLEN_HI_POS)  dlen_in[23:16] = byte_in;
         if (off_ff == DLEN_MID_POS) dlen_in[15:8]  = byte_in;
         if (off_ff == DLEN_LO_POS)  dlen_in[7:0]   = byte_in;
      end
      ahsb_now = {ahs_in, 2'b00};

      unique case (section_ff)
         SEC_HEADER: begin
            result.ahs_bytes  = '0;
            result.data_bytes = '0;
            if (off_ff == HDR_LAST) begin
               result.ahs_bytes  = ahsb_now;
               result.data_bytes = dlen_in;
               off_in            = '0;
               if (ahsb_now != '0) begin
                  section_in = SEC_AHS;
               end else if (dlen_in != '0) begin
                  section_in = SEC_DATA;
               end else begin
                  result.pdu_end = 1'b1;
               end
            end
         end
         SEC_AHS: begin
            if (off_plus1 == {15'b0, ahsb_ff}) begin
               off_in = '0;
               if (dlen_ff == '0) begin
                  result.pdu_end = 1'b1;
                  section_in     = SEC_HEADER;
               end else begin
                  section_in = SEC_DATA;
               end
            end
         end
         SEC_DATA: begin
            if (off_plus1 == {1'b0, dlen_ff}) begin
               off_in = '0;
               if (pad_len == 2'b00) begin
                  result.pdu_end = 1'b1;
                  section_in     = SEC_HEADER;
               end else begin
                  section_in = SEC_PAD;
               end
            end
         end
         SEC_PAD: begin
            if (off_plus1 == {23'b0, pad_len}) begin
               off_in         = '0;
               result.pdu_end = 1'b1;
               section_in     = SEC_HEADER;
            end
         end
         default: begin
            section_in = SEC_HEADER;
         end
      endcase
   end

endmodule
